FILE: design/multi_decade_latency_histogram_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the latency histogram.
// Used by the module that carries concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_DECADE_LATENCY_HISTOGRAM_DEFINES_SVH
`define MULTI_DECADE_LATENCY_HISTOGRAM_DEFINES_SVH

// Implication check under synchronous reset.
`define MDLH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check under synchronous reset.
`define MDLH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/mdlh_pkg.sv
// ----------------------------------------------------------------------------
// mdlh_pkg
// Constants and types shared by the latency histogram modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mdlh_pkg;
    localparam int unsigned BucketsPerRowDef = 1001;
    localparam int unsigned RowsDef          = 7;
    localparam int unsigned CountWidthDef    = 32;
    localparam int unsigned ElapsedWidth     = 36;
    localparam int unsigned PercentWidth     = 7;
    localparam int unsigned ResultWidth      = 34;
    localparam logic [ResultWidth-1:0] NotFoundUsec = 34'd9999000000;

    localparam logic OpRecord = 1'b0;
    localparam logic OpQuery  = 1'b1;

    typedef struct packed {
        logic [0:0]              operation;
        logic [ElapsedWidth-1:0] elapsed_usec;
        logic [PercentWidth-1:0] percent;
    } t_in_word;

    typedef struct packed {
        logic [ResultWidth-1:0] percentile_usec;
    } t_out_word;
endpackage
`default_nettype wire

FILE: design/mdlh_if.sv
// ----------------------------------------------------------------------------
// mdlh_in_if / mdlh_out_if
// Valid-ready channels that carry input and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface mdlh_in_if import mdlh_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mdlh_out_if import mdlh_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/mdlh_ram.sv
// ----------------------------------------------------------------------------
// mdlh_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mdlh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: design/mdlh_index.sv
// ----------------------------------------------------------------------------
// mdlh_index
// Turns an elapsed time into the bucket index of each row, one row at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mdlh_index import mdlh_pkg::*; #(
    parameter int unsigned BUCKETS_PER_ROW = BucketsPerRowDef,
    localparam int unsigned IdxW = $clog2(BUCKETS_PER_ROW)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [ElapsedWidth-1:0] i_value,
    input  wire logic                    i_next,
    output logic      [IdxW-1:0]         o_index
);
    // Holds the running quotient; each row divides it by ten once more.
    // The reciprocal estimate is registered and corrected by one step when
    // the row advances.
    logic [ElapsedWidth-1:0] r_quot;
    logic [ElapsedWidth-1:0] n_quot;
    logic [ElapsedWidth-1:0] r_approx;
    logic [ElapsedWidth-1:0] n_approx;
    logic [ElapsedWidth-1:0] v_rem;

    localparam logic [ElapsedWidth-1:0] Limit = ElapsedWidth'(BUCKETS_PER_ROW - 1);

    always_comb begin
        n_approx = (r_quot >> 1) + (r_quot >> 2);
        n_approx = n_approx + (n_approx >> 4);
        n_approx = n_approx + (n_approx >> 8);
        n_approx = n_approx + (n_approx >> 16);
        n_approx = n_approx + (n_approx >> 32);
        n_approx = n_approx >> 3;
    end

    always_comb begin
        v_rem  = r_quot - ((r_approx << 3) + (r_approx << 1));
        n_quot = (v_rem > ElapsedWidth'(9)) ? r_approx + 1'b1 : r_approx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot   <= '0;
            r_approx <= '0;
        end else begin
            r_approx <= n_approx;
            if (i_start) begin
                r_quot <= i_value;
            end else if (i_next) begin
                r_quot <= n_quot;
            end
        end
    end

    assign o_index = (r_quot > Limit) ? Limit[IdxW-1:0] : r_quot[IdxW-1:0];
endmodule
`default_nettype wire

FILE: design/multi_decade_latency_histogram.sv
// ----------------------------------------------------------------------------
// multi_decade_latency_histogram
// Log-scale latency histogram with percentile query, kept in one RAM.
// ----------------------------------------------------------------------------
// Usage: words enter on i_in (operation, elapsed_usec, percent) and query
// results leave on o_out (percentile_usec). A record word adds one to the
// total and to one bucket in each of ROWS rows; it produces no result and
// does one read, one wait and one write per row on the bucket RAM. A query
// first sums a row and then scans its buckets, adding each to a running sum
// and comparing; it stops at the first qualifying bucket and moves on to
// the next row when a row has none. An empty histogram answers a query with
// zero. After reset the block first clears all ROWS*BUCKETS_PER_ROW RAM
// entries, one entry per cycle, and takes no word meanwhile. A result waits
// in the output register while the receiver stalls; record words are still
// taken, and a following query holds its answer until the output register
// is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multi_decade_latency_histogram_defines.svh"
module multi_decade_latency_histogram import mdlh_pkg::*; #(
    parameter int unsigned BUCKETS_PER_ROW = BucketsPerRowDef,
    parameter int unsigned ROWS            = RowsDef,
    parameter int unsigned COUNT_WIDTH     = CountWidthDef
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    mdlh_in_if.sink   i_in,
    mdlh_out_if.source o_out
);
    localparam int unsigned Depth = ROWS * BUCKETS_PER_ROW;
    localparam int unsigned AddrW = $clog2(Depth);
    localparam int unsigned IdxW  = $clog2(BUCKETS_PER_ROW);
    localparam int unsigned RowW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned CW    = COUNT_WIDTH;
    localparam int unsigned PW    = CW + 7;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RREAD = 10'b0000000100,
        S_RWAIT = 10'b0000001000,
        S_RWRIT = 10'b0000010000,
        S_SUM   = 10'b0000100000,
        S_SCAN  = 10'b0001000000,
        S_CMP   = 10'b0010000000,
        S_MUL   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state                  r_state, n_state;
    logic [AddrW-1:0]        r_addr, n_addr;
    logic [IdxW-1:0]         r_j, n_j;
    logic [RowW-1:0]         r_row, n_row;
    logic [AddrW-1:0]        r_base, n_base;
    logic [CW-1:0]           r_total, n_total;
    logic [CW-1:0]           r_rowsum, n_rowsum;
    logic [CW-1:0]           r_accum, n_accum;
    logic [PercentWidth-1:0] r_pct, n_pct;
    logic [ResultWidth-1:0]  r_unit, n_unit;
    logic [ResultWidth-1:0]  r_lo, n_lo;
    logic [ResultWidth-1:0]  r_res, n_res;
    logic                    r_rd_pend, n_rd_pend;
    logic [PW-1:0]           r_pa, n_pa;
    logic [PW-1:0]           r_ps, n_ps;
    logic                    r_ovalid, n_ovalid;

    logic                    w_we;
    logic [AddrW-1:0]        w_waddr, w_raddr;
    logic [CW-1:0]           w_wdata, w_rdata;
    logic [IdxW-1:0]         w_index;
    logic                    w_acc;
    logic                    w_idx_start;
    logic                    w_idx_next;

    mdlh_ram #(.WIDTH(CW), .DEPTH(Depth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    mdlh_index #(.BUCKETS_PER_ROW(BUCKETS_PER_ROW)) u_index (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_idx_start),
        .i_value(i_in.data.elapsed_usec),
        .i_next (w_idx_next),
        .o_index(w_index)
    );

    assign w_acc        = i_in.valid && i_in.ready;
    assign w_idx_start  = w_acc && (i_in.data.operation == OpRecord);
    assign w_idx_next   = (r_state == S_RWRIT);
    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_ovalid;
    assign o_out.data.percentile_usec = r_res;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_j       = r_j;
        n_row     = r_row;
        n_base    = r_base;
        n_total   = r_total;
        n_rowsum  = r_rowsum;
        n_accum   = r_accum;
        n_pct     = r_pct;
        n_unit    = r_unit;
        n_lo      = r_lo;
        n_res     = r_res;
        n_rd_pend = 1'b0;
        n_pa      = r_pa;
        n_ps      = r_ps;
        n_ovalid  = r_ovalid && !o_out.ready;
        w_we      = 1'b0;
        w_waddr   = r_addr;
        w_wdata   = '0;
        w_raddr   = r_addr;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_addr == AddrW'(Depth - 1)) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                n_row  = '0;
                n_base = '0;
                n_unit = ResultWidth'(1);
                if (w_acc) begin
                    if (i_in.data.operation == OpRecord) begin
                        n_total = r_total + 1'b1;
                        n_state = S_RREAD;
                    end else begin
                        n_pct = i_in.data.percent;
                        if (r_total == '0) begin
                            n_lo    = '0;
                            n_state = S_OUT;
                        end else begin
                            n_addr    = '0;
                            n_j       = '0;
                            n_rowsum  = '0;
                            n_rd_pend = 1'b1;
                            n_state   = S_SUM;
                        end
                    end
                end
            end
            S_RREAD: begin
                n_addr  = r_base + AddrW'(w_index);
                w_raddr = r_base + AddrW'(w_index);
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                n_state = S_RWRIT;
            end
            S_RWRIT: begin
                w_we    = 1'b1;
                w_wdata = w_rdata + 1'b1;
                if (r_row == RowW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_base  = r_base + AddrW'(BUCKETS_PER_ROW);
                    n_state = S_RREAD;
                end
            end
            S_SUM: begin
                w_raddr = r_base + AddrW'(r_j) + AddrW'(r_rd_pend ? 0 : 1);
                if (r_rd_pend) begin
                    n_rd_pend = 1'b0;
                end else begin
                    n_rowsum = r_rowsum + w_rdata;
                    if (r_j == IdxW'(BUCKETS_PER_ROW - 1)) begin
                        n_j       = '0;
                        n_accum   = '0;
                        n_rd_pend = 1'b1;
                        n_state   = S_SCAN;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                w_raddr = r_base + AddrW'(r_j);
                if (r_rd_pend) begin
                    n_rd_pend = 1'b0;
                end else begin
                    n_accum = r_accum + w_rdata;
                    n_lo    = ResultWidth'(r_j) * r_unit;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_pa    = PW'(r_accum) * PW'(100);
                n_ps    = PW'(r_rowsum) * PW'(r_pct);
                n_state = S_CMP;
            end
            S_CMP: begin
                if ((r_pct == '0) ? (r_accum != '0)
                                  : ((r_rowsum != '0) && (r_pa >= r_ps))) begin
                    n_state = S_OUT;
                end else if (r_j != IdxW'(BUCKETS_PER_ROW - 2)) begin
                    n_j       = r_j + 1'b1;
                    n_rd_pend = 1'b1;
                    n_state   = S_SCAN;
                end else if (r_row != RowW'(ROWS - 1)) begin
                    n_row     = r_row + 1'b1;
                    n_base    = r_base + AddrW'(BUCKETS_PER_ROW);
                    n_unit    = ResultWidth'(r_unit * ResultWidth'(10));
                    n_j       = '0;
                    n_rowsum  = '0;
                    n_rd_pend = 1'b1;
                    n_state   = S_SUM;
                end else begin
                    n_lo    = NotFoundUsec;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_res    = r_lo;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_total     <= '0;
            r_ovalid    <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_row       <= '0;
            r_base      <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_total     <= n_total;
            r_ovalid    <= n_ovalid;
            r_rd_pend   <= n_rd_pend;
            r_row       <= n_row;
            r_base      <= n_base;
        end
        r_j      <= n_j;
        r_rowsum <= n_rowsum;
        r_accum  <= n_accum;
        r_pct    <= n_pct;
        r_unit   <= n_unit;
        r_lo     <= n_lo;
        r_res    <= n_res;
        r_pa     <= n_pa;
        r_ps     <= n_ps;
    end

    `MDLH_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !i_in.ready)
    `MDLH_ASSERT_IMP(a_no_write_in_query, i_clk, i_rst_n,
        (r_state == S_SUM) || (r_state == S_SCAN) || (r_state == S_CMP), !w_we)
    `MDLH_ASSERT_NXT(a_out_after_done, i_clk, i_rst_n, r_state == S_OUT, o_out.valid)
endmodule
`default_nettype wire
